/* design/tc22_pkg.sv */
// Shared types and constants for the 2x2 stride-2 transposed convolution core.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps

package tc22_pkg;

	localparam int IN_CH   = 1024;
	localparam int OUT_CH  = 40;
	localparam int TAPS    = 4;
	localparam int IC_W    = 10;
	localparam int OC_W    = 6;
	localparam int ROW_W   = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
	localparam int WDEPTH  = OUT_CH * IN_CH;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int ACC_W   = 48;

	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_BIAS   = 2'd1;
	localparam logic [1:0] KIND_ACT    = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [IC_W-1:0]    in_channel;
		logic [OC_W-1:0]    out_channel;
		logic [1:0]         tap;
		logic [4:0]         pos_y;
		logic [4:0]         pos_x;
		logic [1:0]         plane;
		logic signed [15:0] sample;
		logic signed [31:0] bias_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         out_plane_index;
		logic [5:0]         out_chan;
		logic [5:0]         out_row;
		logic [5:0]         out_col;
		logic signed [31:0] val_00;
		logic signed [31:0] val_01;
		logic signed [31:0] val_10;
		logic signed [31:0] val_11;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MUL,
		S_ACC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             rd;
		logic             mul;
		logic             acc_wr;
		logic             emit;
		logic [ROW_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic act_ok;
		logic last;
		logic out_free;
	} status_t;

endpackage

/* design/tc22_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on tc22_pkg for the payload structs.
`timescale 1ns / 1ps

interface tc22_in_if;
	logic               valid;
	logic               ready;
	tc22_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tc22_out_if;
	logic                valid;
	logic                ready;
	tc22_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/tc22_ctrl.sv */
// Controller: walks output-channel rows for each activation transaction.
// Depends on tc22_pkg; drives the datapath only through cmd_t / status_t.
`timescale 1ns / 1ps

module tc22_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output tc22_pkg::cmd_t    cmd,
	input  tc22_pkg::status_t st
);
	import tc22_pkg::*;

	state_t           state_q, state_d;
	logic [ROW_W-1:0] row_q;
	logic             row_end;
	logic             accept;

	assign row_end = (row_q == ROW_W'(OUT_CH - 1));
	assign accept  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && st.act_ok) state_d = S_RD;
			S_RD:   state_d = S_MUL;
			S_MUL:  state_d = S_ACC;
			S_ACC: begin
				if (st.last) state_d = S_EMIT;
				else if (row_end) state_d = S_IDLE;
				else state_d = S_RD;
			end
			S_EMIT: begin
				if (st.out_free) state_d = row_end ? S_IDLE : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.accept = accept;
		cmd.rd     = (state_q == S_RD);
		cmd.mul    = (state_q == S_MUL);
		cmd.acc_wr = (state_q == S_ACC);
		cmd.emit   = (state_q == S_EMIT) && st.out_free;
		cmd.row    = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				row_q <= '0;
			else if ((state_q == S_ACC && !st.last) || cmd.emit)
				row_q <= row_end ? '0 : row_q + 1'b1;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free) else $error("emit into a full output register");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_W'(OUT_CH - 1)) else $error("row counter out of range");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> st.last) else $error("emit on a non-final channel");

endmodule

/* design/tc22_dpath.sv */
// Datapath: weight, bias and accumulator memories, four tap MACs, output register.
// Depends on tc22_pkg; sequenced by tc22_ctrl.
`timescale 1ns / 1ps

module tc22_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  tc22_pkg::in_item_t  in_data,
	input  tc22_pkg::cmd_t      cmd,
	output tc22_pkg::status_t   st,
	output logic                out_valid,
	input  logic                out_ready,
	output tc22_pkg::out_item_t out_data
);
	import tc22_pkg::*;

	logic [TAPS-1:0][15:0]      wmem [WDEPTH];
	logic [31:0]                bmem [OUT_CH];
	logic [TAPS-1:0][ACC_W-1:0] amem [OUT_CH];
	logic [OUT_CH-1:0]          avalid_q;

	logic [IC_W-1:0]            ic_q;
	logic signed [15:0]         smp_q;
	logic [1:0]                 pl_q;
	logic [4:0]                 py_q, px_q;

	logic [TAPS-1:0][15:0]      w_rd_q;
	logic [TAPS-1:0][ACC_W-1:0] a_rd_q;
	logic                       av_rd_q;
	logic signed [31:0]         b_rd_q;
	logic [TAPS-1:0][31:0]      prod_q;
	logic [TAPS-1:0][ACC_W-1:0] base_q;
	logic [TAPS-1:0][ACC_W-1:0] acc_new;
	logic [TAPS-1:0][ACC_W-1:0] acc_new_q;
	logic [TAPS-1:0][31:0]      sat_val;

	logic                       ic_ok, oc_ok, first;
	logic [WADDR_W-1:0]         w_wr_addr, w_rd_addr;
	logic                       out_valid_q;

	assign ic_ok = int'(in_data.in_channel) < IN_CH;
	assign oc_ok = int'(in_data.out_channel) < OUT_CH;
	assign first = (ic_q == '0);

	assign w_wr_addr = WADDR_W'(in_data.out_channel) * WADDR_W'(IN_CH)
		+ WADDR_W'(in_data.in_channel);
	assign w_rd_addr = WADDR_W'(cmd.row) * WADDR_W'(IN_CH) + WADDR_W'(ic_q);

	assign st.act_ok   = (in_data.kind == KIND_ACT) && ic_ok;
	assign st.last     = (int'(ic_q) == IN_CH - 1);
	assign st.out_free = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;

	// Memories
	always_ff @(posedge clk) begin
		if (cmd.accept && in_data.kind == KIND_WEIGHT && ic_ok && oc_ok)
			wmem[w_wr_addr][in_data.tap] <= in_data.sample;
		if (cmd.rd)
			w_rd_q <= wmem[w_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_data.kind == KIND_BIAS && oc_ok)
			bmem[in_data.out_channel[ROW_W-1:0]] <= in_data.bias_value;
		if (cmd.rd)
			b_rd_q <= bmem[cmd.row];
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_wr)
			amem[cmd.row] <= acc_new;
		if (cmd.rd)
			a_rd_q <= amem[cmd.row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc_wr)
				avalid_q[cmd.row] <= 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Item capture, MAC pipeline
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ic_q  <= in_data.in_channel;
			smp_q <= in_data.sample;
			pl_q  <= in_data.plane;
			py_q  <= in_data.pos_y;
			px_q  <= in_data.pos_x;
		end
		if (cmd.rd)
			av_rd_q <= avalid_q[cmd.row];
		if (cmd.mul) begin
			for (int t = 0; t < TAPS; t++) begin
				prod_q[t] <= 32'($signed(w_rd_q[t]) * smp_q);
				base_q[t] <= (first || !av_rd_q) ? '0 : a_rd_q[t];
			end
		end
		if (cmd.acc_wr)
			acc_new_q <= acc_new;
	end

	always_comb begin
		for (int t = 0; t < TAPS; t++)
			acc_new[t] = base_q[t] + {{(ACC_W-32){prod_q[t][31]}}, prod_q[t]};
	end

	// Bias add and saturation
	always_comb begin
		logic signed [ACC_W:0] sum;
		for (int t = 0; t < TAPS; t++) begin
			sum = $signed({acc_new_q[t][ACC_W-1], acc_new_q[t]})
				+ (ACC_W+1)'(b_rd_q);
			if (sum > (ACC_W+1)'(64'sd2147483647))
				sat_val[t] = 32'h7fff_ffff;
			else if (sum < -(ACC_W+1)'(64'sd2147483648))
				sat_val[t] = 32'h8000_0000;
			else
				sat_val[t] = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data.out_plane_index <= pl_q;
			out_data.out_chan        <= 6'(cmd.row);
			out_data.out_row         <= {py_q, 1'b0};
			out_data.out_col         <= {px_q, 1'b0};
			out_data.val_00          <= sat_val[0];
			out_data.val_01          <= sat_val[1];
			out_data.val_10          <= sat_val[2];
			out_data.val_11          <= sat_val[3];
			out_data.last            <= (cmd.row == ROW_W'(OUT_CH - 1));
		end
	end

endmodule

/* design/transposed_conv2x2_stride2_core.sv */
// Top level of the 2x2 stride-2 transposed convolution core.
// Depends on tc22_pkg, tc22_if, tc22_ctrl and tc22_dpath.
`timescale 1ns / 1ps

// Usage:
//  items (sink): one transaction per input item. kind 0 writes one weight tap,
//    kind 1 writes one bias; both produce nothing.
//    kind 2 is an activation for input channel in_channel of one pixel.
//  Each activation walks the OUT_CH output-channel rows: per row the S_RD step
//    reads the weight row (4 taps) and accumulator row, the S_MUL step
//    multiplies (four 16x16 multipliers), and the S_ACC step adds and writes
//    back. The next transaction is taken only after the walk returns to idle.
//  On the last input channel each row gets a fourth step, S_EMIT, that adds the
//    bias, saturates, and loads the output register; the first result
//    transaction appears after the S_RD, S_MUL, S_ACC and S_EMIT steps of
//    the first row.
//  results (source): OUT_CH transactions per pixel, last set on the final one.
//    A stalled receiver holds the output register; the walk waits on that row.
//  Items are taken only between activations; loads give no results, while
//    kind 3 and out-of-range channels are taken and dropped without results.
//  Reset: control state clears; accumulators read as zero until first written;
//    weight and bias tables are undefined until loaded.

module transposed_conv2x2_stride2_core (
	input  logic          clk,
	input  logic          arst_n,
	tc22_in_if.sink       items,
	tc22_out_if.source    results
);
	import tc22_pkg::*;

	cmd_t    cmd;
	status_t st;

	tc22_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.cmd      (cmd),
		.st       (st)
	);

	tc22_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (items.data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (results.data)
	);

endmodule
